>>> rtl/string_interning_hash_table_macros.svh
// ----------------------------------------------------------------------------
// String interning hash table: assertion macros
// Concurrent assertion wrappers, empty when synthesised.
// ----------------------------------------------------------------------------
`ifndef STRING_INTERNING_HASH_TABLE_MACROS_SVH
`define STRING_INTERNING_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define SIH_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sih assertion failed");
`define SIH_ASSERT_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sih assertion failed");
`else
`define SIH_ASSERT_IMP(lbl, clk, rst_n, a, b)
`define SIH_ASSERT_NXT(lbl, clk, rst_n, a, b)
`endif
`endif

>>> rtl/sih_pkg.sv
// ----------------------------------------------------------------------------
// String interning hash table package
// Shared constants, status codes and the job control struct.
// ----------------------------------------------------------------------------
package sih_pkg;

    localparam int SLOTS_DEF     = 1024;
    localparam int MAX_KEY_DEF   = 32;
    localparam int ID_W          = 10;
    localparam int LIMIT_W       = 11;
    localparam int STATUS_W      = 3;

    localparam logic [31:0]        HASH_SEED   = 32'd5381;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd716;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LIMIT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LONG   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;

    typedef struct packed {
        logic kind;
        logic ovf;
    } t_job_ctl;

endpackage

>>> rtl/sih_front.sv
// ----------------------------------------------------------------------------
// String interning hash table: front end
// Hashes key bytes, buffers them in the queue and pushes a job per key.
// ----------------------------------------------------------------------------
module sih_front #(
    parameter int SW  = 10,
    parameter int KIW = 5,
    parameter int LW  = 6,
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_kind,
    input  logic [7:0]           i_key_byte,
    input  logic                 i_last,
    output logic                 o_byte_we,
    output logic [KIW-1:0]       o_byte_idx,
    output logic [7:0]           o_byte,
    output logic                 o_push,
    output sih_pkg::t_job_ctl    o_ctl,
    output logic [SW-1:0]        o_home,
    output logic [LW-1:0]        o_len
);

    logic [31:0]   r_hash, n_hash;
    logic [LW-1:0] r_len, n_len;
    logic          r_ovf, n_ovf;
    logic          room;

    assign room = (r_len < LW'(MAX_KEY_BYTES));
    assign n_hash = (r_hash << 5) + r_hash + {24'd0, i_key_byte};
    assign n_len  = room ? r_len + 1'b1 : r_len;
    assign n_ovf  = r_ovf | ~room;

    assign o_byte_we  = i_accept & room;
    assign o_byte_idx = r_len[KIW-1:0];
    assign o_byte     = i_key_byte;
    assign o_push     = i_accept & i_last;
    assign o_ctl.kind = i_kind;
    assign o_ctl.ovf  = n_ovf;
    assign o_home     = n_hash[SW-1:0];
    assign o_len      = n_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= sih_pkg::HASH_SEED;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_accept) begin
            if (i_last) begin
                r_hash <= sih_pkg::HASH_SEED;
                r_len  <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_hash <= n_hash;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
            end
        end
    end

endmodule

>>> rtl/sih_queue.sv
// ----------------------------------------------------------------------------
// String interning hash table: job queue
// Two key buffers with their job descriptors between front and back end.
// ----------------------------------------------------------------------------
`include "string_interning_hash_table_macros.svh"

module sih_queue #(
    parameter int SW  = 10,
    parameter int KIW = 5,
    parameter int LW  = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_byte_we,
    input  logic [KIW-1:0]       i_byte_idx,
    input  logic [7:0]           i_byte,
    input  logic                 i_push,
    input  sih_pkg::t_job_ctl    i_ctl,
    input  logic [SW-1:0]        i_home,
    input  logic [LW-1:0]        i_len,
    input  logic                 i_pop,
    input  logic [KIW-1:0]       i_rd_idx,
    output logic                 o_valid,
    output logic                 o_full,
    output sih_pkg::t_job_ctl    o_ctl,
    output logic [SW-1:0]        o_home,
    output logic [LW-1:0]        o_len,
    output logic [7:0]           o_byte
);

    logic [7:0]        mem_key [2*(2**KIW)];
    sih_pkg::t_job_ctl r_ctl  [2];
    logic [SW-1:0]     r_home [2];
    logic [LW-1:0]     r_len  [2];
    logic [1:0]        r_cnt;
    logic              r_wr;
    logic              r_rd;
    logic [7:0]        r_byte;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_ctl   = r_ctl[r_rd];
    assign o_home  = r_home[r_rd];
    assign o_len   = r_len[r_rd];
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            mem_key[{r_wr, i_byte_idx}] <= i_byte;
        end
        r_byte <= mem_key[{r_rd, i_rd_idx}];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr]  <= i_ctl;
            r_home[r_wr] <= i_home;
            r_len[r_wr]  <= i_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `SIH_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, r_cnt != 2'd2)
    `SIH_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_cnt != 2'd0)
    `SIH_ASSERT_NXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, r_cnt != 2'd0)

endmodule

>>> rtl/sih_back.sv
// ----------------------------------------------------------------------------
// String interning hash table: back end
// Linear probe engine over the slot tables, with insert and clearing pass.
// ----------------------------------------------------------------------------
`include "string_interning_hash_table_macros.svh"

module sih_back #(
    parameter int SLOTS = 1024,
    parameter int SW    = 10,
    parameter int KIW   = 5,
    parameter int LW    = 6
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sih_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    input  logic                         i_job_valid,
    input  sih_pkg::t_job_ctl            i_ctl,
    input  logic [SW-1:0]                i_home,
    input  logic [LW-1:0]                i_len,
    input  logic [7:0]                   i_qbyte,
    output logic                         o_pop,
    output logic [KIW-1:0]               o_rd_idx,
    output logic                         o_clearing,
    output logic                         o_done,
    output logic [sih_pkg::STATUS_W-1:0] o_status,
    output logic [sih_pkg::ID_W-1:0]     o_entry_id
);

    localparam int MW = 1 + LW + sih_pkg::ID_W;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_META   = 4'd2;
    localparam logic [3:0] S_CHECK  = 4'd3;
    localparam logic [3:0] S_CMP_RD = 4'd4;
    localparam logic [3:0] S_CMP    = 4'd5;
    localparam logic [3:0] S_CP_RD  = 4'd6;
    localparam logic [3:0] S_CP_WR  = 4'd7;

    logic [MW-1:0] mem_meta [SLOTS];
    logic [7:0]    mem_key  [SLOTS*(2**KIW)];

    logic [3:0]                       r_state, n_state;
    logic [SW-1:0]                    r_slot, n_slot;
    logic [SW:0]                      r_probes, n_probes;
    logic [KIW-1:0]                   r_j, n_j;
    logic [SW-1:0]                    r_clr, n_clr;
    logic [sih_pkg::LIMIT_W-1:0]      r_count, n_count;
    logic [sih_pkg::LIMIT_W-1:0]      r_limit;
    logic                             r_done, n_done;
    logic [sih_pkg::STATUS_W-1:0]     r_status, n_status;
    logic [sih_pkg::ID_W-1:0]         r_id, n_id;
    logic [MW-1:0]                    r_meta;
    logic [7:0]                       r_kbyte;

    logic                             meta_we;
    logic [SW-1:0]                    meta_wa;
    logic [MW-1:0]                    meta_wd;
    logic                             key_we;
    logic                             m_valid;
    logic [LW-1:0]                    m_len;
    logic [sih_pkg::ID_W-1:0]         m_id;
    logic [SW:0]                      probes_inc;
    logic                             probe_end;
    logic                             byte_end;
    logic                             at_limit;

    assign m_valid    = r_meta[MW-1];
    assign m_len      = r_meta[MW-2 -: LW];
    assign m_id       = r_meta[sih_pkg::ID_W-1:0];
    assign probes_inc = r_probes + 1'b1;
    assign probe_end  = (probes_inc == (SW+1)'(SLOTS));
    assign byte_end   = ((LW'(r_j) + 1'b1) == i_len);
    assign at_limit   = (r_count >= r_limit);

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            mem_meta[meta_wa] <= meta_wd;
        end
        r_meta <= mem_meta[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_key[{r_slot, r_j}] <= i_qbyte;
        end
        r_kbyte <= mem_key[{r_slot, r_j}];
    end

    always_comb begin
        n_state  = r_state;
        n_slot   = r_slot;
        n_probes = r_probes;
        n_j      = r_j;
        n_clr    = r_clr;
        n_count  = r_count;
        n_done   = 1'b0;
        n_status = r_status;
        n_id     = r_id;
        o_pop    = 1'b0;
        meta_we  = 1'b0;
        meta_wa  = r_slot;
        meta_wd  = {1'b1, i_len, r_count[sih_pkg::ID_W-1:0]};
        key_we   = 1'b0;
        case (r_state)
            S_CLEAR: begin
                meta_we = 1'b1;
                meta_wa = r_clr;
                meta_wd = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == SW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_job_valid) begin
                    if (i_ctl.ovf) begin
                        n_done   = 1'b1;
                        n_status = sih_pkg::ST_LONG;
                        n_id     = '0;
                        o_pop    = 1'b1;
                    end else begin
                        n_slot   = i_home;
                        n_probes = '0;
                        n_state  = S_META;
                    end
                end
            end
            S_META: begin
                n_state = S_CHECK;
            end
            S_CHECK, S_CMP: begin
                if ((r_state == S_CHECK && !m_valid) || probe_end &&
                    (r_state == S_CHECK ? (m_len != i_len) : (r_kbyte != i_qbyte))) begin
                    // A free slot ends the probe, and so does a fruitless sweep of the table.
                    if (!i_ctl.kind) begin
                        n_done   = 1'b1;
                        n_status = sih_pkg::ST_ABSENT;
                        n_id     = '0;
                        o_pop    = 1'b1;
                        n_state  = S_IDLE;
                    end else if (at_limit || m_valid) begin
                        n_done   = 1'b1;
                        n_status = sih_pkg::ST_LIMIT;
                        n_id     = '0;
                        o_pop    = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        meta_we = 1'b1;
                        n_j     = '0;
                        n_state = S_CP_RD;
                    end
                end else if (r_state == S_CHECK ? (m_len != i_len)
                                                : (r_kbyte != i_qbyte)) begin
                    n_slot   = r_slot + 1'b1;
                    n_probes = probes_inc;
                    n_state  = S_META;
                end else if (r_state == S_CHECK) begin
                    n_j     = '0;
                    n_state = S_CMP_RD;
                end else if (byte_end) begin
                    n_done   = 1'b1;
                    n_status = i_ctl.kind ? sih_pkg::ST_DUP : sih_pkg::ST_OK;
                    n_id     = m_id;
                    o_pop    = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_CMP_RD;
                end
            end
            S_CMP_RD: begin
                n_state = S_CMP;
            end
            S_CP_RD: begin
                n_state = S_CP_WR;
            end
            S_CP_WR: begin
                key_we = 1'b1;
                if (byte_end) begin
                    n_done   = 1'b1;
                    n_status = sih_pkg::ST_OK;
                    n_id     = r_count[sih_pkg::ID_W-1:0];
                    n_count  = r_count + 1'b1;
                    o_pop    = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_CP_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_limit  <= sih_pkg::LIMIT_RESET;
            r_done   <= 1'b0;
            r_slot   <= '0;
            r_probes <= '0;
            r_j      <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_count  <= n_count;
            r_done   <= n_done;
            r_slot   <= n_slot;
            r_probes <= n_probes;
            r_j      <= n_j;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_id     <= n_id;
    end

    assign o_rd_idx   = r_j;
    assign o_clearing = (r_state == S_CLEAR);
    assign o_done     = r_done;
    assign o_status   = r_status;
    assign o_entry_id = r_id;

    `SIH_ASSERT_IMP(a_pop_has_job, i_clk, i_rst_n, o_pop, i_job_valid)
    `SIH_ASSERT_IMP(a_fail_zero_id, i_clk, i_rst_n,
        r_done && (r_status == sih_pkg::ST_ABSENT || r_status == sih_pkg::ST_LIMIT ||
                   r_status == sih_pkg::ST_LONG), r_id == '0)
    `SIH_ASSERT_IMP(a_count_on_add, i_clk, i_rst_n, r_count != $past(r_count),
        r_done && r_status == sih_pkg::ST_OK)

endmodule

>>> rtl/string_interning_hash_table.sv
// ----------------------------------------------------------------------------
// String interning hash table
// Interns byte-serial keys by djb2 hash and linear probing; returns dense IDs.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+----------------------
//  input    | i_kind, i_key_byte, i_last              | start high, busy low
//  result   | o_status, o_entry_id                    | o_done, one cycle
//  config   | i_cfg_wdata                             | i_cfg_we
//
//  The front end hashes each key byte as it is accepted. After a key's last beat
//  the back end runs S_META and S_CHECK per probed slot, S_CMP_RD and S_CMP per
//  compared byte and S_CP_RD and S_CP_WR per byte stored on an insert, all set
//  by the single read port of each slot memory. A two-key queue lets the front
//  end take the next key meanwhile; busy rises when both key buffers are in use.
//  After reset, clearing every slot holds busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module string_interning_hash_table #(
    parameter int SLOTS         = sih_pkg::SLOTS_DEF,
    parameter int MAX_KEY_BYTES = sih_pkg::MAX_KEY_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_kind,
    input  logic [7:0]                   i_key_byte,
    input  logic                         i_last,
    input  logic                         i_cfg_we,
    input  logic [sih_pkg::LIMIT_W-1:0]  i_cfg_wdata,
    output logic                         o_done,
    output logic [sih_pkg::STATUS_W-1:0] o_status,
    output logic [sih_pkg::ID_W-1:0]     o_entry_id
);

    localparam int SW  = $clog2(SLOTS);
    localparam int KIW = $clog2(MAX_KEY_BYTES);
    localparam int LW  = $clog2(MAX_KEY_BYTES + 1);

    logic              accept;
    logic              byte_we;
    logic [KIW-1:0]    byte_idx;
    logic [7:0]        wbyte;
    logic              push;
    sih_pkg::t_job_ctl f_ctl;
    logic [SW-1:0]     f_home;
    logic [LW-1:0]     f_len;
    logic              q_valid;
    logic              q_full;
    sih_pkg::t_job_ctl q_ctl;
    logic [SW-1:0]     q_home;
    logic [LW-1:0]     q_len;
    logic [7:0]        q_byte;
    logic              pop;
    logic [KIW-1:0]    rd_idx;
    logic              clearing;

    assign busy   = q_full | clearing;
    assign accept = start & ~busy;

    sih_front #(
        .SW(SW), .KIW(KIW), .LW(LW), .MAX_KEY_BYTES(MAX_KEY_BYTES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_kind(i_kind), .i_key_byte(i_key_byte), .i_last(i_last),
        .o_byte_we(byte_we), .o_byte_idx(byte_idx), .o_byte(wbyte),
        .o_push(push), .o_ctl(f_ctl), .o_home(f_home), .o_len(f_len)
    );

    sih_queue #(
        .SW(SW), .KIW(KIW), .LW(LW)
    ) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte_we(byte_we), .i_byte_idx(byte_idx), .i_byte(wbyte),
        .i_push(push), .i_ctl(f_ctl), .i_home(f_home), .i_len(f_len),
        .i_pop(pop), .i_rd_idx(rd_idx),
        .o_valid(q_valid), .o_full(q_full), .o_ctl(q_ctl), .o_home(q_home),
        .o_len(q_len), .o_byte(q_byte)
    );

    sih_back #(
        .SLOTS(SLOTS), .SW(SW), .KIW(KIW), .LW(LW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_job_valid(q_valid), .i_ctl(q_ctl), .i_home(q_home), .i_len(q_len),
        .i_qbyte(q_byte), .o_pop(pop), .o_rd_idx(rd_idx), .o_clearing(clearing),
        .o_done(o_done), .o_status(o_status), .o_entry_id(o_entry_id)
    );

endmodule
